@@ sv/ets_pkg.sv @@
// Shared types, constants and character classes for the expression token scanner.
// Used by ets_word_match, ets_result_fifo and expression_token_scanner.
// No dependencies.
package ets_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_IDENT = 3'd1,
    PH_INT   = 3'd2,
    PH_FRAC  = 3'd3,
    PH_DOT   = 3'd4,
    PH_EXPE  = 3'd5,
    PH_EXPS  = 3'd6,
    PH_EXPD  = 3'd7
  } phase_t;

  localparam logic [5:0] KIND_END = 6'd0;
  localparam logic [5:0] KIND_ID  = 6'd1;
  localparam logic [5:0] KIND_NUM = 6'd2;
  localparam logic [5:0] KIND_KW0 = 6'd3;
  localparam logic [5:0] KIND_OP0 = 6'd22;
  localparam logic [5:0] KIND_ERR = 6'd32;

  localparam int NUM_KW     = 19;
  localparam int NUM_OPS    = 10;
  localparam int PREFIX_LEN = 5;

  // Keyword text, first character in the top byte, zero padded on the right.
  localparam logic [39:0] KW_TEXT [NUM_KW] = '{
    {"sin", 16'h0}, {"cos", 16'h0}, {"tan", 16'h0},
    {"asin", 8'h0}, {"acos", 8'h0}, {"atan", 8'h0},
    {"log", 16'h0}, {"exp", 16'h0}, "log10", "exp10",
    {"sqrt", 8'h0}, {"rnd", 16'h0}, "round", "floor",
    {"fabs", 8'h0}, "expm1", {"sinh", 8'h0}, {"tanh", 8'h0},
    {"cbrt", 8'h0}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd5, 3'd5,
    3'd4, 3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4
  };

  localparam logic [7:0] OPS [NUM_OPS] = '{
    "=", "+", "-", "*", "/", "%", "^", "(", ")", ","
  };

  localparam logic [7:0] CH_POINT = ".";
  localparam logic [7:0] CH_E_LO  = "e";
  localparam logic [7:0] CH_E_HI  = "E";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] length;
    logic       last;
  } result_t;

  // Up to two results from one input beat; en1 only with en0.
  typedef struct packed {
    logic    en0;
    logic    en1;
    result_t r0;
    result_t r1;
  } result_pair_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_exp_mark(input logic [7:0] c);
    return (c == CH_E_LO) || (c == CH_E_HI);
  endfunction

  // Operator kind, or KIND_ERR when the byte is not an operator.
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] k;
    k = KIND_ERR;
    for (int i = 0; i < NUM_OPS; i++) begin
      if (c == OPS[i]) k = KIND_OP0 + 6'(i);
    end
    return k;
  endfunction

endpackage

@@ sv/ets_word_match.sv @@
// Keyword lookup for a finished identifier: compares the stored prefix with
// the 19 function names. Depends on ets_pkg.
module ets_word_match (
  input  logic [39:0] text,   // first character in the top byte
  input  logic [2:0]  len,    // 0 when the word is too long to be a keyword
  output logic [5:0]  kind
);

  logic [39:0] mask;

  always_comb begin
    for (int i = 0; i < ets_pkg::PREFIX_LEN; i++) begin
      mask[39 - 8*i -: 8] = (3'(i) < len) ? 8'hFF : 8'h00;
    end
    kind = ets_pkg::KIND_ID;
    for (int k = 0; k < ets_pkg::NUM_KW; k++) begin
      if ((len == ets_pkg::KW_LEN[k]) &&
          ((text & mask) == (ets_pkg::KW_TEXT[k] & mask))) begin
        kind = ets_pkg::KIND_KW0 + 6'(k);
      end
    end
  end

endmodule

@@ sv/ets_result_fifo.sv @@
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on ets_pkg.
module ets_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  ets_pkg::result_pair_t wr,
  output logic                  room,      // space for two more results
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output ets_pkg::result_t      rd_data
);

  ets_pkg::result_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;
  logic [2:0] n_push;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count != 3'd0);
  assign rd_data  = mem[rd_ptr];
  assign room     = (count <= 3'd2);
  assign n_push   = {2'b00, wr.en0} + {2'b00, wr.en1};

  always_comb begin
    count_next = count + n_push - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en0) mem[wr_ptr] <= wr.r0;
    if (wr.en1) mem[wr_ptr + 2'd1] <= wr.r1;
  end

endmodule

@@ sv/expression_token_scanner.sv @@
// Expression token scanner: one character beat in, token beats out.
// Top level; depends on ets_pkg, ets_word_match and ets_result_fifo.
//
// Input channel (in_valid/in_ready): one byte of expression text per beat in
// character, or stream_end high to close the stream. Output channel
// (out_valid/out_ready): token_kind, token_length (saturates at 255) and last,
// which marks the final result caused by an input beat.
// The scanner state is updated in the cycle a beat is accepted and its
// results go into a four-entry result queue, from which they are offered
// on the output in order.
// Throughput: one input beat per cycle while out_ready is high and each beat
// gives at most one result. A beat that ends a token and is an operator or an
// unknown byte, or a stream end in an open token, gives two results; the queue
// drains one per cycle, so in_ready drops when fewer than two slots are free.
// A stall on the output only fills the queue; in_ready falls when it is near
// full and no result is ever dropped.
// Reset (rst, synchronous) empties the queue and returns the scanner to idle
// with a zero length count. The identifier prefix store is not cleared.
module expression_token_scanner #(
  parameter int LENGTH_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       stream_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] token_kind,
  output logic [7:0] token_length,
  output logic       last
);

  localparam int LB = LENGTH_BITS;
  localparam int OW = (LB > 8) ? LB : 8;

  ets_pkg::phase_t phase;
  ets_pkg::phase_t phase_next;
  logic [LB-1:0]   cnt;
  logic [LB-1:0]   cnt_next;
  logic [LB-1:0]   cnt_inc;
  logic [7:0]      prefix [ets_pkg::PREFIX_LEN];

  logic            acc;
  logic [39:0]     word_text;
  logic [2:0]      word_len;
  logic [5:0]      word_kind;

  // begin-of-token decode of the current byte
  ets_pkg::phase_t bg_phase;
  logic            bg_push;
  logic            bg_res;
  logic [5:0]      bg_kind;

  logic            fl_v;
  logic [5:0]      fl_kind;
  logic            sc_v;
  logic [5:0]      sc_kind;
  logic [LB-1:0]   sc_cnt;
  logic            take_begin;
  logic            push;
  logic            fail;

  ets_pkg::result_pair_t pair;
  ets_pkg::result_t      head;
  logic                  room;

  function automatic logic [7:0] out_len(input logic [LB-1:0] v);
    logic [OW-1:0] w;
    w = OW'(v);
    return (w > OW'(255)) ? 8'hFF : w[7:0];
  endfunction

  assign acc     = in_valid && in_ready;
  assign in_ready = room;
  assign cnt_inc = (cnt == {LB{1'b1}}) ? cnt : cnt + LB'(1);

  assign word_text = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4]};
  assign word_len  = (cnt <= LB'(ets_pkg::PREFIX_LEN)) ? cnt[2:0] : 3'd0;

  ets_word_match u_match (
    .text (word_text),
    .len  (word_len),
    .kind (word_kind)
  );

  always_comb begin
    bg_phase = ets_pkg::PH_IDLE;
    bg_push  = 1'b0;
    bg_res   = 1'b0;
    bg_kind  = ets_pkg::KIND_ERR;
    if (ets_pkg::is_space(character)) begin
      bg_res = 1'b0;
    end else if (ets_pkg::is_alpha(character)) begin
      bg_phase = ets_pkg::PH_IDENT;
      bg_push  = 1'b1;
    end else if (ets_pkg::is_digit(character)) begin
      bg_phase = ets_pkg::PH_INT;
      bg_push  = 1'b1;
    end else if (character == ets_pkg::CH_POINT) begin
      bg_phase = ets_pkg::PH_DOT;
      bg_push  = 1'b1;
    end else begin
      bg_res  = 1'b1;
      bg_kind = ets_pkg::op_kind(character);
    end
  end

  always_comb begin
    fl_v       = 1'b0;
    fl_kind    = ets_pkg::KIND_NUM;
    sc_v       = 1'b0;
    sc_kind    = ets_pkg::KIND_END;
    sc_cnt     = '0;
    take_begin = 1'b0;
    push       = 1'b0;
    fail       = 1'b0;
    phase_next = phase;
    cnt_next   = cnt;
    if (stream_end) begin
      case (phase)
        ets_pkg::PH_IDENT: begin
          fl_v    = 1'b1;
          fl_kind = word_kind;
        end
        ets_pkg::PH_INT, ets_pkg::PH_FRAC, ets_pkg::PH_EXPD: begin
          fl_v    = 1'b1;
          fl_kind = ets_pkg::KIND_NUM;
        end
        ets_pkg::PH_DOT, ets_pkg::PH_EXPE, ets_pkg::PH_EXPS: begin
          fl_v    = 1'b1;
          fl_kind = ets_pkg::KIND_ERR;
        end
        default: fl_v = 1'b0;
      endcase
      sc_v       = 1'b1;
      phase_next = ets_pkg::PH_IDLE;
      cnt_next   = '0;
    end else begin
      case (phase)
        ets_pkg::PH_IDENT: begin
          if (ets_pkg::is_alpha(character) || ets_pkg::is_digit(character)) begin
            push = 1'b1;
          end else begin
            fl_v       = 1'b1;
            fl_kind    = word_kind;
            take_begin = 1'b1;
          end
        end
        ets_pkg::PH_INT: begin
          if (ets_pkg::is_digit(character)) begin
            push = 1'b1;
          end else if (character == ets_pkg::CH_POINT) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_FRAC;
          end else if (ets_pkg::is_exp_mark(character)) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_EXPE;
          end else begin
            fl_v       = 1'b1;
            take_begin = 1'b1;
          end
        end
        ets_pkg::PH_FRAC: begin
          if (ets_pkg::is_digit(character)) begin
            push = 1'b1;
          end else if (ets_pkg::is_exp_mark(character)) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_EXPE;
          end else begin
            fl_v       = 1'b1;
            take_begin = 1'b1;
          end
        end
        ets_pkg::PH_DOT: begin
          if (ets_pkg::is_digit(character)) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_FRAC;
          end else begin
            fail = 1'b1;
          end
        end
        ets_pkg::PH_EXPE: begin
          if ((character == ets_pkg::CH_PLUS) || (character == ets_pkg::CH_MINUS)) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_EXPS;
          end else if (ets_pkg::is_digit(character)) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_EXPD;
          end else begin
            fail = 1'b1;
          end
        end
        ets_pkg::PH_EXPS: begin
          if (ets_pkg::is_digit(character)) begin
            push       = 1'b1;
            phase_next = ets_pkg::PH_EXPD;
          end else begin
            fail = 1'b1;
          end
        end
        ets_pkg::PH_EXPD: begin
          if (ets_pkg::is_digit(character)) begin
            push = 1'b1;
          end else begin
            fl_v       = 1'b1;
            take_begin = 1'b1;
          end
        end
        default: take_begin = 1'b1;
      endcase

      if (take_begin) begin
        // terminator is rescanned as the start of a new token
        phase_next = bg_phase;
        cnt_next   = bg_push ? LB'(1) : '0;
        sc_v       = bg_res;
        sc_kind    = bg_kind;
        sc_cnt     = LB'(1);
      end else if (fail) begin
        // offending character counts toward the error and is consumed
        phase_next = ets_pkg::PH_IDLE;
        cnt_next   = '0;
        sc_v       = 1'b1;
        sc_kind    = ets_pkg::KIND_ERR;
        sc_cnt     = cnt_inc;
      end else if (push) begin
        cnt_next = cnt_inc;
      end
    end
  end

  always_comb begin
    pair.en0       = acc && (fl_v || sc_v);
    pair.en1       = acc && fl_v && sc_v;
    pair.r1.kind   = sc_kind;
    pair.r1.length = out_len(sc_cnt);
    pair.r1.last   = 1'b1;
    if (fl_v) begin
      pair.r0.kind   = fl_kind;
      pair.r0.length = out_len(cnt);
      pair.r0.last   = !sc_v;
    end else begin
      pair.r0 = pair.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ets_pkg::PH_IDLE;
      cnt   <= '0;
    end else if (acc) begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !stream_end) begin
      if (take_begin && bg_push) begin
        prefix[0] <= character;
      end else if (push && (cnt < LB'(ets_pkg::PREFIX_LEN))) begin
        prefix[cnt[2:0]] <= character;
      end
    end
  end

  ets_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (pair),
    .room     (room),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign token_kind   = head.kind;
  assign token_length = head.length;
  assign last         = head.last;

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    acc && stream_end |=> (phase == ets_pkg::PH_IDLE) && (cnt == '0))
    else $error("scanner not idle after end of stream");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == ets_pkg::PH_IDLE) == (cnt == '0))
    else $error("length count disagrees with scan phase");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    pair.en1 |-> pair.en0 && !pair.r0.last)
    else $error("second result without an open first result");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    !acc |-> !pair.en0)
    else $error("result queued without an accepted beat");

endmodule

@@ sim/testbench.sv @@
// Testbench for expression_token_scanner: drives character beats and stream ends
// with bursty input and a stalling output, predicts every token and checks it.
// Depends on ets_pkg (result and phase types, kind codes, character constants).
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 350;

  // Function names, first character in the top byte, zero padded.
  localparam logic [39:0] FN_NAMES [19] = '{
    {"sin", 16'h0}, {"cos", 16'h0}, {"tan", 16'h0}, {"asin", 8'h0},
    {"acos", 8'h0}, {"atan", 8'h0}, {"log", 16'h0}, {"exp", 16'h0},
    "log10", "exp10", {"sqrt", 8'h0}, {"rnd", 16'h0}, "round", "floor",
    {"fabs", 8'h0}, "expm1", {"sinh", 8'h0}, {"tanh", 8'h0}, {"cbrt", 8'h0}
  };
  localparam logic [7:0] OP_CHARS [10] = '{
    "=", "+", "-", "*", "/", "%", "^", "(", ")", ","
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] character = 8'h00;
  logic       stream_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [5:0] token_kind;
  logic [7:0] token_length;
  logic       last;

  expression_token_scanner dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .character(character), .stream_end(stream_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .token_length(token_length), .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scanner model state
  ets_pkg::phase_t  scan_ph = ets_pkg::PH_IDLE;
  logic [7:0]       word_buf [5];
  logic [7:0]       word_len = 8'd0;
  ets_pkg::result_t step_tok [2];
  int               step_cnt;
  ets_pkg::result_t exp_tokens [$];

  int fail_count = 0;
  int beats_in = 0;
  int tokens_out = 0;
  int kw_seen = 0;
  int err_seen = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  function automatic logic ch_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic ch_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic ch_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] sat_next(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [5:0] word_kind();
    logic [39:0] w;
    logic [5:0]  k;
    int          i;
    w = '0;
    k = ets_pkg::KIND_ID;
    // longer words can never be function names
    if (word_len <= 8'd5) begin
      for (i = 0; i < 5; i++)
        if (i < word_len) w[39 - 8*i -: 8] = word_buf[i];
      for (i = 0; i < 19; i++)
        if (w == FN_NAMES[i]) k = ets_pkg::KIND_KW0 + 6'(i);
    end
    return k;
  endfunction

  task note_token(input logic [5:0] kind, input logic [7:0] len);
    step_tok[step_cnt] = '{kind: kind, length: len, last: 1'b0};
    step_cnt++;
  endtask

  task take_char(input logic [7:0] c);
    if (word_len < 8'd5) word_buf[word_len] = c;
    word_len = sat_next(word_len);
  endtask

  task reject_token();
    // offending character is part of the error and is not rescanned
    note_token(ets_pkg::KIND_ERR, sat_next(word_len));
    scan_ph = ets_pkg::PH_IDLE;
    word_len = 8'd0;
  endtask

  task start_token(input logic [7:0] c);
    logic [5:0] k;
    int         i;
    scan_ph = ets_pkg::PH_IDLE;
    word_len = 8'd0;
    if (ch_space(c)) return;
    if (ch_letter(c)) begin
      take_char(c);
      scan_ph = ets_pkg::PH_IDENT;
    end else if (ch_digit(c)) begin
      take_char(c);
      scan_ph = ets_pkg::PH_INT;
    end else if (c == ets_pkg::CH_POINT) begin
      take_char(c);
      scan_ph = ets_pkg::PH_DOT;
    end else begin
      k = ets_pkg::KIND_ERR;
      for (i = 0; i < 10; i++)
        if (c == OP_CHARS[i]) k = ets_pkg::KIND_OP0 + 6'(i);
      note_token(k, 8'd1);
    end
  endtask

  task predict_beat(input logic [7:0] c, input logic fin);
    ets_pkg::result_t r;
    int               i;
    step_cnt = 0;
    if (fin) begin
      case (scan_ph)
        ets_pkg::PH_IDENT: note_token(word_kind(), word_len);
        ets_pkg::PH_INT, ets_pkg::PH_FRAC, ets_pkg::PH_EXPD:
          note_token(ets_pkg::KIND_NUM, word_len);
        ets_pkg::PH_DOT, ets_pkg::PH_EXPE, ets_pkg::PH_EXPS:
          note_token(ets_pkg::KIND_ERR, word_len);
        default: ;
      endcase
      note_token(ets_pkg::KIND_END, 8'd0);
      scan_ph = ets_pkg::PH_IDLE;
      word_len = 8'd0;
    end else begin
      case (scan_ph)
        ets_pkg::PH_IDENT: begin
          if (ch_letter(c) || ch_digit(c)) take_char(c);
          else begin
            note_token(word_kind(), word_len);
            start_token(c);
          end
        end
        ets_pkg::PH_INT, ets_pkg::PH_FRAC: begin
          if (ch_digit(c)) take_char(c);
          else if (c == ets_pkg::CH_POINT && scan_ph == ets_pkg::PH_INT) begin
            take_char(c);
            scan_ph = ets_pkg::PH_FRAC;
          end else if (c == ets_pkg::CH_E_LO || c == ets_pkg::CH_E_HI) begin
            take_char(c);
            scan_ph = ets_pkg::PH_EXPE;
          end else begin
            note_token(ets_pkg::KIND_NUM, word_len);
            start_token(c);
          end
        end
        ets_pkg::PH_DOT: begin
          if (ch_digit(c)) begin
            take_char(c);
            scan_ph = ets_pkg::PH_FRAC;
          end else reject_token();
        end
        ets_pkg::PH_EXPE: begin
          if (c == ets_pkg::CH_PLUS || c == ets_pkg::CH_MINUS) begin
            take_char(c);
            scan_ph = ets_pkg::PH_EXPS;
          end else if (ch_digit(c)) begin
            take_char(c);
            scan_ph = ets_pkg::PH_EXPD;
          end else reject_token();
        end
        ets_pkg::PH_EXPS: begin
          if (ch_digit(c)) begin
            take_char(c);
            scan_ph = ets_pkg::PH_EXPD;
          end else reject_token();
        end
        ets_pkg::PH_EXPD: begin
          if (ch_digit(c)) take_char(c);
          else begin
            note_token(ets_pkg::KIND_NUM, word_len);
            start_token(c);
          end
        end
        default: start_token(c);
      endcase
    end
    for (i = 0; i < step_cnt; i++) begin
      r = step_tok[i];
      r.last = (i == step_cnt - 1);
      exp_tokens.push_back(r);
    end
  endtask

  // Predict on accepted input beats, then check accepted output beats.
  always @(posedge clk) begin : check_tokens
    ets_pkg::result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_beat(character, stream_end);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        tokens_out++;
        if (exp_tokens.size() == 0) begin
          $error("unexpected token: kind %0d length %0d last %0d",
                 token_kind, token_length, last);
          fail_count++;
        end else begin
          want = exp_tokens.pop_front();
          if (token_kind != want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
            fail_count++;
          end
          if (token_length != want.length) begin
            $error("token_length: expected %0d, got %0d", want.length, token_length);
            fail_count++;
          end
          if (last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            fail_count++;
          end
          if (want.kind >= ets_pkg::KIND_KW0 && want.kind < ets_pkg::KIND_OP0) kw_seen++;
          if (want.kind == ets_pkg::KIND_ERR) err_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $error("no beat moved for %0d cycles, %0d tokens outstanding",
             STALL_LIMIT, exp_tokens.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Output backpressure: modes of random length, one of them a rotating mask.
  int          ready_mode = 0;
  int          ready_mode_left = 0;
  logic [15:0] ready_mask = 16'h0001;

  always @(negedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(20, 200);
      ready_mask = 16'($urandom) | 16'h0001;
    end
    ready_mode_left--;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: begin
        ready_mask = {ready_mask[14:0], ready_mask[15]};
        out_ready <= ready_mask[0];
      end
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // One input beat; returns just after the edge that accepts it.
  task automatic send_beat(input logic [7:0] ch, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    character <= ch;
    stream_end <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 1) ? 8'($urandom_range("a", "z"))
                                       : 8'($urandom_range("A", "Z"));
  endfunction

  task automatic test_operators();
    send_string("=+-*/%^(),");
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_special_cases();
    send_beat(8'h00, 1'b0);        // stray control byte
    send_beat(8'hFF, 1'b0);        // non-ASCII byte
    send_string(".x");             // point without digit
    send_string("7e!");            // exponent without digit
    send_string("1E-");
    send_beat(8'h00, 1'b1);        // end on an unfinished exponent
    send_string("pi");
    send_beat(8'hFF, 1'b1);        // end right after a word, character ignored
    send_beat(8'h00, 1'b1);        // end while idle
  endtask

  // Lengths past the counter limit must saturate.
  task automatic test_long_tokens();
    int i;
    send_beat("q", 1'b0);
    for (i = 1; i < 300; i++)
      send_beat(($urandom_range(0, 2) == 0) ? 8'($urandom_range("0", "9")) : rand_letter(),
                1'b0);
    send_beat("+", 1'b0);
    for (i = 0; i < 262; i++) send_beat(8'($urandom_range("0", "9")), 1'b0);
    send_beat(" ", 1'b0);
    for (i = 0; i < 258; i++) send_beat(8'($urandom_range("0", "9")), 1'b0);
    send_beat("e", 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_random_stream();
    logic [7:0] txt [$];
    int         pick, n, i, sent;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      txt.delete();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        n = $urandom_range(0, 18);
        for (i = 0; i < 5; i++)
          if (FN_NAMES[n][39 - 8*i -: 8] != 8'h00) txt.push_back(FN_NAMES[n][39 - 8*i -: 8]);
      end else if (pick < 35) begin
        n = $urandom_range(1, 8);
        txt.push_back(rand_letter());
        for (i = 1; i < n; i++)
          txt.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range("0", "9"))
                                                     : rand_letter());
      end else if (pick < 55) begin
        if ($urandom_range(0, 3) == 0) begin
          txt.push_back(ets_pkg::CH_POINT);
          repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range("0", "9")));
        end else begin
          repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range("0", "9")));
          if ($urandom_range(0, 1) == 1) begin
            txt.push_back(ets_pkg::CH_POINT);
            repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range("0", "9")));
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          txt.push_back(($urandom_range(0, 1) == 1) ? ets_pkg::CH_E_LO : ets_pkg::CH_E_HI);
          case ($urandom_range(0, 2))
            0: txt.push_back(ets_pkg::CH_PLUS);
            1: txt.push_back(ets_pkg::CH_MINUS);
            default: ;
          endcase
          repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range("0", "9")));
        end
      end else if (pick < 75) begin
        txt.push_back(OP_CHARS[$urandom_range(0, 9)]);
      end else if (pick < 85) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        // broken number: cut off after a point, an exponent mark or a sign
        case ($urandom_range(0, 2))
          0: txt.push_back(ets_pkg::CH_POINT);
          1: begin
            txt.push_back(8'($urandom_range("0", "9")));
            txt.push_back(ets_pkg::CH_E_LO);
          end
          default: begin
            txt.push_back(8'($urandom_range("0", "9")));
            txt.push_back(ets_pkg::CH_E_HI);
            txt.push_back(ets_pkg::CH_MINUS);
          end
        endcase
        txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        sent++;
      end
      case ($urandom_range(0, 3))
        0: txt.push_back(" ");
        1: txt.push_back(8'($urandom_range(9, 13)));
        default: ;
      endcase
      for (i = 0; i < txt.size(); i++) begin
        send_beat(txt[i], 1'b0);
        sent++;
      end
    end
    send_beat(8'h00, 1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_operators();
    test_special_cases();
    test_long_tokens();
    test_random_stream();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Scanned %0d character and end beats into %0d tokens", beats_in, tokens_out);
    $display("(%0d function names, %0d lexical errors), %0d mismatches",
             kw_seen, err_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
